// ----- rtl/core/lmsr_pkg.sv -----
// ----------------------------------------------------------------------------
// lmsr_pkg
// Shared types, constants and color helper of the LED matrix scan refresh.
// ----------------------------------------------------------------------------
package lmsr_pkg;

  localparam int unsigned COLOR_W    = 6;
  localparam int unsigned RGB_W      = 3;
  localparam int unsigned PHASE_W    = 2;
  localparam int unsigned ROW_ADDR_W = 5;

  localparam logic [PHASE_W-1:0] PHASE_LAST = 2'd2;

  // Kind of work that one queued word asks of the back end.
  typedef enum logic [1:0] {
    OP_STORE,
    OP_SHIFT,
    OP_LATCH
  } op_e;

  // Control part of one queued word; frame addresses travel beside it.
  typedef struct packed {
    op_e                   op;
    logic                  first_ok;
    logic                  second_ok;
    logic [PHASE_W-1:0]    phase;
    logic [ROW_ADDR_W-1:0] row_addr;
    logic [COLOR_W-1:0]    color;
  } entry_ctl_t;

  // One result word as it waits in the output queue.
  typedef struct packed {
    logic                  shift_valid;
    logic [RGB_W-1:0]      first_rgb;
    logic [RGB_W-1:0]      second_rgb;
    logic                  latch_pulse;
    logic [ROW_ADDR_W-1:0] row_address;
  } result_t;

  // Lit bits of one pixel: bit 0 red, bit 1 green, bit 2 blue.
  function automatic logic [RGB_W-1:0] lit_bits(input logic [COLOR_W-1:0] c,
                                                input logic               mode,
                                                input logic [PHASE_W-1:0] phase);
    logic [RGB_W-1:0] bits;
    if (mode) begin
      bits[0] = phase < c[5:4];
      bits[1] = phase < c[3:2];
      bits[2] = phase < c[1:0];
    end else begin
      bits[0] = c[5];
      bits[1] = c[3];
      bits[2] = c[1];
    end
    return bits;
  endfunction

endpackage

// ----- rtl/core/lmsr_ram.sv -----
// ----------------------------------------------------------------------------
// lmsr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lmsr_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/lmsr_fifo.sv -----
// ----------------------------------------------------------------------------
// lmsr_fifo
// Small register queue with push/full and pop/empty sides and a fill count.
// ----------------------------------------------------------------------------
module lmsr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic [CNT_W-1:0] count_o
);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rptr_q];
  assign count_o = count_q;

  // Pointer and count update.
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Slot storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/core/lmsr_front.sv -----
// ----------------------------------------------------------------------------
// lmsr_front
// Accepts input words, tracks the scan position and turns each word into a
// store, a column shift or a row latch with its frame addresses worked out.
// ----------------------------------------------------------------------------
module lmsr_front #(
  parameter int unsigned PANEL_WIDTH   = 64,
  parameter int unsigned SCAN_ROWS     = 16,
  parameter int unsigned LINES_PER_ROW = 4,
  parameter int unsigned PANEL_HEIGHT  = 64,
  localparam int unsigned AW = $clog2(PANEL_WIDTH * PANEL_HEIGHT)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic                                command_i,
  input  logic [5:0]                          pixel_x_i,
  input  logic [5:0]                          pixel_y_i,
  input  logic [lmsr_pkg::COLOR_W-1:0]        pixel_color_i,
  input  logic                                color_mode_i,
  output lmsr_pkg::entry_ctl_t                ctl_o,
  output logic [AW-1:0]                       addr_a_o,
  output logic [AW-1:0]                       addr_b_o
);

  import lmsr_pkg::*;

  localparam int unsigned PASS_COUNT = (LINES_PER_ROW + 1) / 2;
  localparam int unsigned CW  = $clog2(PANEL_WIDTH);
  localparam int unsigned PSW = $clog2(PASS_COUNT + 1);
  localparam int unsigned SRW = $clog2(SCAN_ROWS);

  logic [CW-1:0]      col_q, col_d;
  logic [PSW-1:0]     pass_q, pass_d;
  logic [SRW-1:0]     scan_row_q, scan_row_d;
  logic [PHASE_W-1:0] color_phase_q, color_phase_d;
  logic               tick_acc;
  logic               in_shift;
  int                 first_i;
  int                 second_i;

  assign tick_acc = accept_i && command_i;
  assign in_shift = (pass_q < PSW'(PASS_COUNT));

  // Paired frame rows of the current pass.
  always_comb begin
    first_i  = int'(scan_row_q)
               + (int'(LINES_PER_ROW) - 1 - 2 * int'(pass_q)) * int'(SCAN_ROWS);
    second_i = first_i - int'(SCAN_ROWS);
  end

  // Classify the word and form its queue entry.
  always_comb begin
    ctl_o          = '0;
    addr_a_o       = '0;
    addr_b_o       = '0;
    ctl_o.phase    = color_phase_q;
    ctl_o.color    = pixel_color_i;
    if (!command_i) begin
      ctl_o.op       = OP_STORE;
      ctl_o.first_ok = (int'(pixel_x_i) < int'(PANEL_WIDTH))
                       && (int'(pixel_y_i) < int'(PANEL_HEIGHT));
      addr_a_o       = AW'(int'(pixel_y_i) * int'(PANEL_WIDTH) + int'(pixel_x_i));
    end else if (in_shift) begin
      ctl_o.op        = OP_SHIFT;
      ctl_o.first_ok  = (first_i >= 0) && (first_i < int'(PANEL_HEIGHT));
      ctl_o.second_ok = (second_i >= 0) && (second_i < int'(PANEL_HEIGHT));
      addr_a_o        = AW'(first_i * int'(PANEL_WIDTH) + int'(col_q));
      addr_b_o        = AW'(second_i * int'(PANEL_WIDTH) + int'(col_q));
    end else begin
      ctl_o.op       = OP_LATCH;
      ctl_o.row_addr = ROW_ADDR_W'(scan_row_q);
    end
  end

  // Scan position: column within pass, pass, scan row and color phase.
  always_comb begin
    col_d         = col_q;
    pass_d        = pass_q;
    scan_row_d    = scan_row_q;
    color_phase_d = color_phase_q;
    if (tick_acc) begin
      if (in_shift) begin
        if (col_q == CW'(PANEL_WIDTH - 1)) begin
          col_d  = '0;
          pass_d = pass_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end else begin
        col_d  = '0;
        pass_d = '0;
        if (scan_row_q == SRW'(SCAN_ROWS - 1)) begin
          scan_row_d = '0;
          if (color_mode_i) begin
            color_phase_d = (color_phase_q == PHASE_LAST) ? '0 : color_phase_q + 1'b1;
          end
        end else begin
          scan_row_d = scan_row_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q         <= '0;
      pass_q        <= '0;
      scan_row_q    <= '0;
      color_phase_q <= '0;
    end else begin
      col_q         <= col_d;
      pass_q        <= pass_d;
      scan_row_q    <= scan_row_d;
      color_phase_q <= color_phase_d;
    end
  end

  // A latch tick restarts the row at its first column of its first pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_acc && !in_shift) |=> (col_q == '0 && pass_q == '0))
    else $error("scan position not restarted after latch");

  // The color phase holds while three-bit mode is selected.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !color_mode_i |=> $stable(color_phase_q))
    else $error("color phase moved in three-bit mode");

endmodule

// ----- rtl/core/lmsr_back.sv -----
// ----------------------------------------------------------------------------
// lmsr_back
// Clears the frame after reset, carries out queued stores, reads both paired
// rows for a column word and hands finished results to the output queue.
// ----------------------------------------------------------------------------
module lmsr_back #(
  parameter int unsigned MEM_DEPTH = 4096,
  parameter int unsigned OUT_DEPTH = 4,
  localparam int unsigned AW  = $clog2(MEM_DEPTH),
  localparam int unsigned OCW = $clog2(OUT_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 color_mode_i,
  input  logic                 cmd_empty_i,
  input  lmsr_pkg::entry_ctl_t cmd_ctl_i,
  input  logic [AW-1:0]        cmd_addr_a_i,
  input  logic [AW-1:0]        cmd_addr_b_i,
  output logic                 cmd_pop_o,
  input  logic [OCW-1:0]       out_count_i,
  output logic                 out_push_o,
  output lmsr_pkg::result_t    out_data_o,
  output logic                 busy_o
);

  import lmsr_pkg::*;

  logic               clearing_q, clearing_d;
  logic [AW-1:0]      clr_cnt_q, clr_cnt_d;
  logic               s2_valid_q, s2_valid_d;
  entry_ctl_t         s2_ctl_q;
  logic               credit;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [COLOR_W-1:0] ram_wdata;
  logic [COLOR_W-1:0] rdata_a;
  logic [COLOR_W-1:0] rdata_b;

  // Room in the output queue for one more word beyond the one in flight.
  assign credit = ({1'b0, out_count_i} + (OCW + 1)'(s2_valid_q)) < (OCW + 1)'(OUT_DEPTH);

  assign cmd_pop_o = !cmd_empty_i && !clearing_q
                     && ((cmd_ctl_i.op == OP_STORE) || credit);
  assign busy_o    = clearing_q;

  // Clearing pass over the whole frame after reset.
  always_comb begin
    clearing_d = clearing_q;
    clr_cnt_d  = clr_cnt_q;
    if (clearing_q) begin
      if (clr_cnt_q == AW'(MEM_DEPTH - 1)) begin
        clearing_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
    end
  end

  // Frame write: zeros while clearing, otherwise an in-panel store.
  always_comb begin
    ram_we    = clearing_q || (cmd_pop_o && cmd_ctl_i.op == OP_STORE && cmd_ctl_i.first_ok);
    ram_waddr = clearing_q ? clr_cnt_q : cmd_addr_a_i;
    ram_wdata = clearing_q ? '0 : cmd_ctl_i.color;
  end

  // Both copies take every write, so both rows of a pair are read at once.
  lmsr_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(MEM_DEPTH)
  ) u_ram_first (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(cmd_addr_a_i),
    .rdata_o(rdata_a)
  );

  lmsr_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(MEM_DEPTH)
  ) u_ram_second (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(cmd_addr_b_i),
    .rdata_o(rdata_b)
  );

  // Words that produce a result move into the read-data stage.
  assign s2_valid_d = cmd_pop_o && ((cmd_ctl_i.op == OP_SHIFT) || (cmd_ctl_i.op == OP_LATCH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      clearing_q <= clearing_d;
      clr_cnt_q  <= clr_cnt_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      s2_ctl_q <= cmd_ctl_i;
    end
  end

  // Result word from the read data.
  always_comb begin
    out_data_o = '0;
    case (s2_ctl_q.op)
      OP_SHIFT: begin
        out_data_o.shift_valid = 1'b1;
        out_data_o.first_rgb   = s2_ctl_q.first_ok
                                 ? lit_bits(rdata_a, color_mode_i, s2_ctl_q.phase) : '0;
        out_data_o.second_rgb  = s2_ctl_q.second_ok
                                 ? lit_bits(rdata_b, color_mode_i, s2_ctl_q.phase) : '0;
      end
      OP_LATCH: begin
        out_data_o.latch_pulse = 1'b1;
        out_data_o.row_address = s2_ctl_q.row_addr;
      end
      default: begin
        out_data_o = '0;
      end
    endcase
  end

  assign out_push_o = s2_valid_q;

  // A result never arrives at a full output queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (out_count_i < OCW'(OUT_DEPTH)))
    else $error("result pushed into full output queue");

  // No queued word is carried out while the frame is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !cmd_pop_o)
    else $error("command taken during clearing pass");

endmodule

// ----- rtl/core/led_matrix_scan_refresh.sv -----
// ----------------------------------------------------------------------------
// led_matrix_scan_refresh
// Row-scanned RGB LED matrix refresh engine with a stored 6-bit color frame.
//
//   Channel   Handshake                      Payload
//   input     push / full                    command, pixel_x, pixel_y, pixel_color
//   result    empty / pop                    shift_valid, first/second_rgb,
//                                            latch_pulse, row_address
//   config    cfg_valid_i / cfg_ready_o      cfg_color_mode_i
//
// One word is taken every cycle while full is low. A tick's result passes
// through the command queue, the registered frame read and the output queue.
// After reset full stays high while the frame store is cleared one entry per
// cycle; configuration is taken always. When pop stays low the output queue
// fills, the back end holds at the next tick, and full rises once the command
// queue is full as well. Stores give no result.
// ----------------------------------------------------------------------------
module led_matrix_scan_refresh #(
  parameter int unsigned PANEL_WIDTH   = 64,
  parameter int unsigned SCAN_ROWS     = 16,
  parameter int unsigned LINES_PER_ROW = 4,
  parameter int unsigned PANEL_HEIGHT  = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic                              command_i,
  input  logic [5:0]                        pixel_x_i,
  input  logic [5:0]                        pixel_y_i,
  input  logic [lmsr_pkg::COLOR_W-1:0]      pixel_color_i,
  output logic                              empty,
  input  logic                              pop,
  output logic                              shift_valid_o,
  output logic [lmsr_pkg::RGB_W-1:0]        first_rgb_o,
  output logic [lmsr_pkg::RGB_W-1:0]        second_rgb_o,
  output logic                              latch_pulse_o,
  output logic [lmsr_pkg::ROW_ADDR_W-1:0]   row_address_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_color_mode_i
);

  import lmsr_pkg::*;

  localparam int unsigned MEM_DEPTH = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned CTL_W     = $bits(entry_ctl_t);
  localparam int unsigned CMD_W     = CTL_W + 2 * AW;
  localparam int unsigned RES_W     = $bits(result_t);
  localparam int unsigned CCW       = $clog2(CMD_DEPTH + 1);
  localparam int unsigned OCW       = $clog2(OUT_DEPTH + 1);

  logic             color_mode_q;
  logic             accept;
  logic             busy;
  logic             cmd_full;
  logic             cmd_empty;
  logic             cmd_pop;
  logic [CCW-1:0]   cmd_count;
  logic [CMD_W-1:0] cmd_wdata;
  logic [CMD_W-1:0] cmd_rdata;
  entry_ctl_t       front_ctl;
  logic [AW-1:0]    front_addr_a;
  logic [AW-1:0]    front_addr_b;
  entry_ctl_t       back_ctl;
  logic [AW-1:0]    back_addr_a;
  logic [AW-1:0]    back_addr_b;
  logic             out_push;
  result_t          out_wdata;
  result_t          out_rdata;
  logic [RES_W-1:0] out_rdata_raw;
  logic             out_full;
  logic [OCW-1:0]   out_count;

  // Color mode register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      color_mode_q <= cfg_color_mode_i;
    end
  end

  // Input side.
  assign full   = cmd_full || busy;
  assign accept = push && !full;

  lmsr_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .SCAN_ROWS    (SCAN_ROWS),
    .LINES_PER_ROW(LINES_PER_ROW),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .command_i    (command_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .pixel_color_i(pixel_color_i),
    .color_mode_i (color_mode_q),
    .ctl_o        (front_ctl),
    .addr_a_o     (front_addr_a),
    .addr_b_o     (front_addr_b)
  );

  // Command queue between front and back.
  assign cmd_wdata = {front_ctl, front_addr_a, front_addr_b};

  lmsr_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .wdata_i(cmd_wdata),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_rdata),
    .empty_o(cmd_empty),
    .count_o(cmd_count)
  );

  assign back_ctl    = entry_ctl_t'(cmd_rdata[CMD_W-1 -: CTL_W]);
  assign back_addr_a = cmd_rdata[2*AW-1 -: AW];
  assign back_addr_b = cmd_rdata[AW-1:0];

  lmsr_back #(
    .MEM_DEPTH(MEM_DEPTH),
    .OUT_DEPTH(OUT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .color_mode_i(color_mode_q),
    .cmd_empty_i (cmd_empty),
    .cmd_ctl_i   (back_ctl),
    .cmd_addr_a_i(back_addr_a),
    .cmd_addr_b_i(back_addr_b),
    .cmd_pop_o   (cmd_pop),
    .out_count_i (out_count),
    .out_push_o  (out_push),
    .out_data_o  (out_wdata),
    .busy_o      (busy)
  );

  // Output queue toward the panel side.
  lmsr_fifo #(
    .WIDTH(RES_W),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .wdata_i(out_wdata),
    .full_o (out_full),
    .pop_i  (pop),
    .rdata_o(out_rdata_raw),
    .empty_o(empty),
    .count_o(out_count)
  );

  assign out_rdata     = result_t'(out_rdata_raw);
  assign shift_valid_o = out_rdata.shift_valid;
  assign first_rgb_o   = out_rdata.first_rgb;
  assign second_rgb_o  = out_rdata.second_rgb;
  assign latch_pulse_o = out_rdata.latch_pulse;
  assign row_address_o = out_rdata.row_address;

  // Nothing enters the command queue while the frame is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !accept)
    else $error("word accepted during clearing pass");

  // The command queue never overfills from the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_count == CCW'(CMD_DEPTH)) |-> (cmd_full && !accept && !out_full) || (cmd_full && !accept))
    else $error("command queue overfilled");

endmodule

// ----- bench/tb_led_matrix_scan_refresh.sv -----
// ----------------------------------------------------------------------------
// tb_led_matrix_scan_refresh
// Self-checking bench for the LED matrix scan refresh engine. Pixel stores and
// scan ticks are pushed through the input queue with random gaps. Every tick
// runs through a predictor that holds its own copy of the frame, the column
// count, the scan row and the color phase. The words that come out are
// compared field by field, in order, with the predicted words. The run covers
// both color modes, a mode change in the middle of a scan row, several row
// latches and random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_led_matrix_scan_refresh;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PANEL_W    = 64;
  localparam int SCAN_N     = 16;
  localparam int LINES_N    = 4;
  localparam int PANEL_H    = 64;
  localparam int PASSES     = (LINES_N + 1) / 2;
  localparam int SHIFT_LEN  = PASSES * PANEL_W;
  localparam int QUIET_CYC  = 16;
  localparam int DRAIN_CYC  = 2000;
  localparam int RUN_LIMIT  = 4_000_000;

  localparam bit CMD_STORE = 1'b0;
  localparam bit CMD_TICK  = 1'b1;
  localparam bit MODE_ONE_BIT = 1'b0;
  localparam bit MODE_PHASED  = 1'b1;

  typedef struct {
    bit       cmd;
    bit [5:0] x;
    bit [5:0] y;
    bit [5:0] color;
  } scan_item_t;

  // DUT connections; every input starts at a known value.
  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       push             = 1'b0;
  logic       full;
  logic       command_i        = 1'b0;
  logic [5:0] pixel_x_i        = '0;
  logic [5:0] pixel_y_i        = '0;
  logic [5:0] pixel_color_i    = '0;
  logic       empty;
  logic       pop              = 1'b0;
  logic       shift_valid_o;
  logic [2:0] first_rgb_o;
  logic [2:0] second_rgb_o;
  logic       latch_pulse_o;
  logic [4:0] row_address_o;
  logic       cfg_valid_i      = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_color_mode_i = 1'b0;

  // Stimulus and scoreboard state.
  scan_item_t         pending_items[$];
  scan_item_t         next_item;
  lmsr_pkg::result_t  expected_words[$];
  bit                 word_taken;
  bit                 idle_on = 1'b1;
  int                 send_gap;
  int                 stall_left;
  int                 words_queued;
  int                 words_taken;
  int                 words_checked;
  int                 store_count;
  int                 tick_count;
  int                 latch_count;
  int                 wrap_count;
  int                 error_count;

  // Predicted copy of the block's state.
  bit [5:0]           frame_mem [PANEL_H*PANEL_W];
  int                 col_cnt;
  int                 scan_row;
  bit [1:0]           phase_q;
  bit                 mode_q;
  bit [2:0]           phases_seen;

  led_matrix_scan_refresh #(
    .PANEL_WIDTH  (PANEL_W),
    .SCAN_ROWS    (SCAN_N),
    .LINES_PER_ROW(LINES_N),
    .PANEL_HEIGHT (PANEL_H)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .command_i       (command_i),
    .pixel_x_i       (pixel_x_i),
    .pixel_y_i       (pixel_y_i),
    .pixel_color_i   (pixel_color_i),
    .empty           (empty),
    .pop             (pop),
    .shift_valid_o   (shift_valid_o),
    .first_rgb_o     (first_rgb_o),
    .second_rgb_o    (second_rgb_o),
    .latch_pulse_o   (latch_pulse_o),
    .row_address_o   (row_address_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_color_mode_i(cfg_color_mode_i)
  );

  // Clock: 1 ns high, 1 ns low.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop for a hung run.
  initial begin
    #RUN_LIMIT;
    $display("TB_ERROR");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // Lit channels of one stored color in the current mode and phase.
  function automatic bit [2:0] pixel_bits(bit [5:0] color);
    bit [2:0] lit;
    if (mode_q) begin
      lit[0] = phase_q < color[5:4];
      lit[1] = phase_q < color[3:2];
      lit[2] = phase_q < color[1:0];
    end else begin
      lit = {color[1], color[3], color[5]};
    end
    return lit;
  endfunction

  // A paired row outside the frame shows dark.
  function automatic bit [2:0] row_bits(int row, int col);
    if (row < 0 || row >= PANEL_H || col >= PANEL_W) return 3'b000;
    return pixel_bits(frame_mem[row*PANEL_W + col]);
  endfunction

  // Apply one accepted word to the predicted state, queue its result if any.
  task automatic predict_word(bit cmd, bit [5:0] x, bit [5:0] y, bit [5:0] color);
    lmsr_pkg::result_t word;
    int pass_idx;
    int col;
    int top_row;
    if (cmd == CMD_STORE) begin
      if (x < PANEL_W && y < PANEL_H) frame_mem[y*PANEL_W + x] = color;
      return;
    end
    word = '0;
    if (col_cnt < SHIFT_LEN) begin
      pass_idx = col_cnt / PANEL_W;
      col = col_cnt % PANEL_W;
      top_row = scan_row + (LINES_N - 1 - 2*pass_idx) * SCAN_N;
      word.shift_valid = 1'b1;
      word.first_rgb = row_bits(top_row, col);
      word.second_rgb = row_bits(top_row - SCAN_N, col);
      col_cnt++;
    end else begin
      word.latch_pulse = 1'b1;
      word.row_address = 5'(scan_row);
      col_cnt = 0;
      scan_row = (scan_row + 1) % SCAN_N;
      if (scan_row == 0) begin
        wrap_count++;
        if (mode_q) phase_q = (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
      end
    end
    if (mode_q) phases_seen[phase_q] = 1'b1;
    expected_words.push_back(word);
  endtask

  // One line per mismatch, and count it.
  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("MISMATCH word %0d: %s got %0d expected %0d", words_checked, what, got, want);
  endtask

  // Compare the word on the result ports with the oldest expectation.
  task automatic check_word();
    lmsr_pkg::result_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("word with nothing expected, shift_valid", shift_valid_o, 0);
      return;
    end
    want = expected_words.pop_front();
    if (shift_valid_o !== want.shift_valid)
      report_mismatch("shift_valid", shift_valid_o, want.shift_valid);
    if (first_rgb_o !== want.first_rgb)
      report_mismatch("first_rgb", first_rgb_o, want.first_rgb);
    if (second_rgb_o !== want.second_rgb)
      report_mismatch("second_rgb", second_rgb_o, want.second_rgb);
    if (latch_pulse_o !== want.latch_pulse)
      report_mismatch("latch_pulse", latch_pulse_o, want.latch_pulse);
    if (row_address_o !== want.row_address)
      report_mismatch("row_address", row_address_o, want.row_address);
    if (want.latch_pulse) latch_count++;
    words_checked++;
  endtask

  // Input driver: holds a word until it is taken, then waits out a gap.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!push || word_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (pending_items.size() > 0) begin
        next_item = pending_items.pop_front();
        command_i <= next_item.cmd;
        pixel_x_i <= next_item.x;
        pixel_y_i <= next_item.y;
        pixel_color_i <= next_item.color;
        push <= 1'b1;
        send_gap = gap_len();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result side: pop stays high except during random stalls.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 99) < 25) stall_left = gap_len();
    end
  end

  // Monitor: config writes, accepted words and delivered results.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      word_taken = 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) mode_q = cfg_color_mode_i;
      word_taken = push && !full;
      if (word_taken) begin
        words_taken++;
        predict_word(command_i, pixel_x_i, pixel_y_i, pixel_color_i);
      end
      if (pop && !empty) check_word();
    end
  end

  task automatic queue_store(bit [5:0] x, bit [5:0] y, bit [5:0] color);
    scan_item_t it;
    it.cmd = CMD_STORE;
    it.x = x;
    it.y = y;
    it.color = color;
    pending_items.push_back(it);
    words_queued++;
    store_count++;
  endtask

  task automatic queue_tick();
    scan_item_t it;
    it.cmd = CMD_TICK;
    it.x = 6'($urandom);
    it.y = 6'($urandom);
    it.color = 6'($urandom);
    pending_items.push_back(it);
    words_queued++;
    tick_count++;
  endtask

  // Bursts of ticks between pixel stores; stores favor the first columns so
  // that scanned rows carry color.
  task automatic queue_mix(int n, int tick_pct);
    int done;
    int burst;
    done = 0;
    while (done < n) begin
      if ($urandom_range(0, 99) < tick_pct) begin
        burst = $urandom_range(1, 40);
        repeat (burst) queue_tick();
        done += burst;
      end else begin
        queue_store(($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(0, 7)),
                    6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
        done++;
      end
    end
  endtask

  // Hold the sender until every word is taken and every result has come,
  // then let trailing stores settle. Ends at a rising edge.
  task automatic drain_results();
    int waited;
    do @(negedge clk_i); while (words_taken != words_queued);
    waited = 0;
    while (expected_words.size() != 0 && waited < DRAIN_CYC) begin
      @(negedge clk_i);
      waited++;
    end
    if (expected_words.size() != 0) begin
      report_mismatch("words never delivered", 0, expected_words.size());
      expected_words.delete();
    end
    repeat (QUIET_CYC) @(posedge clk_i);
  endtask

  // Write the color mode register; ends at a rising edge.
  task automatic write_mode(bit mode);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_color_mode_i <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stimulus sequence.
  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    write_mode(MODE_ONE_BIT);

    // Directed: corner pixels and contrasting colors on the first columns of
    // the rows that the first pass of scan row 0 shows.
    queue_store(6'd0, 6'd0, 6'h3F);
    queue_store(6'd63, 6'd63, 6'h3F);
    queue_store(6'd63, 6'd0, 6'h15);
    queue_store(6'd0, 6'd63, 6'h2A);
    queue_store(6'd0, 6'd48, 6'h2A);
    queue_store(6'd0, 6'd32, 6'h15);
    queue_store(6'd1, 6'd48, 6'h20);
    queue_store(6'd1, 6'd32, 6'h08);
    queue_store(6'd2, 6'd48, 6'h02);
    queue_store(6'd2, 6'd32, 6'h3F);
    queue_store(6'd3, 6'd48, 6'h15);
    queue_store(6'd3, 6'd32, 6'h3F);
    queue_store(6'd4, 6'd48, 6'h24);
    queue_store(6'd4, 6'd32, 6'h15);
    repeat (4) queue_tick();
    drain_results();

    // Mode change in the middle of a scan row: the next column uses it.
    write_mode(MODE_PHASED);
    repeat (4) queue_tick();
    drain_results();

    // Random mix in both modes, the sender paused in between.
    idle_on = 1'b1;
    queue_mix(190, 55);
    drain_results();
    write_mode(MODE_ONE_BIT);
    idle_on = $urandom_range(0, 1);
    queue_mix(190, 55);
    drain_results();

    $display("Checked %0d result words (%0d row latches) from %0d stores and %0d ticks.",
             words_checked, latch_count, store_count, tick_count);
    $display("Scanned %0d full frames; color phases seen in phased mode: %b.",
             wrap_count, phases_seen);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/lmsr_pkg.sv
rtl/core/lmsr_ram.sv
rtl/core/lmsr_fifo.sv
rtl/core/lmsr_front.sv
rtl/core/lmsr_back.sv
rtl/core/led_matrix_scan_refresh.sv
bench/tb_led_matrix_scan_refresh.sv
